/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RCE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A cause that must be followed by an effect in the next cycle.
`define RCE_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

/* rtl/core/rce_pkg.sv */
package rce_pkg;

  localparam int MAX_PENDING    = 16;
  localparam int BIT_PROB_SHIFT = 13;
  localparam int SYM_PROB_SHIFT = 15;
  localparam int RUN_BOUND      = (MAX_PENDING > 31) ? 31 : MAX_PENDING;
  localparam int MAX_OUT        = 24;
  localparam int MUL_A_W        = 19;
  localparam int PROD_W         = MUL_A_W + 32;

  localparam logic [31:0] MIN_LEN      = 32'h0100_0000;
  localparam logic [31:0] FLUSH_LIMIT  = 32'h0200_0000;
  localparam logic [12:0] PROB_MAX     = 13'((1 << BIT_PROB_SHIFT) - 1);
  localparam logic [15:0] SYM_FULL     = 16'(1 << SYM_PROB_SHIFT);
  localparam logic [7:0]  BYTE_FF      = 8'hFF;
  localparam logic [7:0]  BYTE_00      = 8'h00;

  typedef enum logic [1:0] {
    CMD_BIT   = 2'd0,
    CMD_SYM   = 2'd1,
    CMD_RAW   = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_RAW_SHIFT,
    OP_APPLY,
    OP_CARRY,
    OP_RN_INIT,
    OP_RENORM,
    OP_REL_HEAD,
    OP_REL_TAIL,
    OP_REL_DONE,
    OP_RAW_SPLIT,
    OP_FINISH,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic raw_zero;
    logic raw_split;
    logic carry;
    logic held_valid;
    logic pend_zero;
    logic pend_one;
    logic len_small;
    logic n_done;
    logic push_release;
    logic out_free;
    logic drain_last;
    logic wcount_zero;
  } dp_stat_t;

endpackage

/* rtl/core/rce_if.sv */
interface rce_in_if;
  import rce_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        bit_value;
  logic [12:0] prob_zero;
  logic [14:0] cum_low;
  logic [15:0] cum_high;
  logic        is_last_symbol;
  logic [5:0]  raw_count;
  logic [31:0] raw_value;

  modport source (output valid, command, bit_value, prob_zero, cum_low, cum_high,
                  is_last_symbol, raw_count, raw_value, input ready);
  modport sink (input valid, command, bit_value, prob_zero, cum_low, cum_high,
                is_last_symbol, raw_count, raw_value, output ready);
endinterface

interface rce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;
  logic       run_overflow;

  modport source (output valid, out_byte, last_of_run, stream_end, run_overflow,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, stream_end, run_overflow,
                output ready);
endinterface

/* rtl/core/rce_datapath.sv */
module rce_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rce_pkg::dp_ctl_t  ctl,
  output rce_pkg::dp_stat_t stat,
  input  logic [1:0]        command,
  input  logic              bit_value,
  input  logic [12:0]       prob_zero,
  input  logic [14:0]       cum_low,
  input  logic [15:0]       cum_high,
  input  logic              is_last_symbol,
  input  logic [5:0]        raw_count,
  input  logic [31:0]       raw_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_of_run,
  output logic              stream_end,
  output logic              run_overflow
);
  import rce_pkg::*;

  logic [31:0] base, len, x, y;
  logic [7:0]  held, nb, tb;
  logic        held_valid, ovf, carry;
  logic [4:0]  pend;
  logic [2:0]  n;
  cmd_t        cmd_q;
  logic        bit_q, last_q;
  logic [12:0] p_q;
  logic [14:0] lo_q;
  logic [15:0] hi_q;
  logic [5:0]  cnt_q;
  logic [31:0] val_q;
  logic [7:0]  obuf [MAX_OUT];
  logic [4:0]  wcount, ridx;
  logic        out_ovf, flushed;

  // Load-time clamping of the input fields.
  logic [12:0] p_c;
  logic [14:0] lo_c;
  logic [15:0] hi_t, hi_c;
  logic [5:0]  cnt_c;
  logic [31:0] val_c;

  always_comb begin
    p_c = (prob_zero == 13'd0) ? 13'd1 : prob_zero;
    if (p_c > PROB_MAX) p_c = PROB_MAX;
    lo_c = (16'(cum_low) > SYM_FULL - 16'd1) ? 15'(SYM_FULL - 16'd1) : cum_low;
    hi_t = (cum_high > SYM_FULL) ? SYM_FULL : cum_high;
    hi_c = (hi_t <= 16'(lo_c)) ? 16'(lo_c) + 16'd1 : hi_t;
    cnt_c = (raw_count > 6'd32) ? 6'd32 : raw_count;
    val_c = (cnt_c < 6'd32) ? (raw_value & ~({32{1'b1}} << cnt_c[4:0])) : raw_value;
  end

  // Shared multiplier, one product per cycle into x or y.
  logic [MUL_A_W-1:0] mul_a;
  logic [31:0]        mul_b;
  logic [PROD_W-1:0]  prod;
  logic               raw_split;

  assign raw_split = (cnt_q > 6'd19);

  always_comb begin
    case (cmd_q)
      CMD_BIT: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = len >> BIT_PROB_SHIFT;
      end
      CMD_SYM: begin
        mul_a = (ctl.op == OP_MUL_HI) ? MUL_A_W'(hi_q) : MUL_A_W'(lo_q);
        mul_b = len >> SYM_PROB_SHIFT;
      end
      default: begin
        mul_a = raw_split ? MUL_A_W'(val_q[15:0]) : val_q[MUL_A_W-1:0];
        mul_b = len;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  logic [31:0] addend, len_apply;
  logic        do_add;
  logic [32:0] sum;
  logic        flush_big;

  always_comb begin
    flush_big = (len > FLUSH_LIMIT);
    do_add    = 1'b1;
    addend    = x;
    len_apply = len;
    case (cmd_q)
      CMD_BIT: begin
        do_add    = bit_q;
        len_apply = bit_q ? len - x : x;
      end
      CMD_SYM:   len_apply = last_q ? len - x : y - x;
      CMD_RAW:   len_apply = len;
      default: begin
        addend    = flush_big ? MIN_LEN : (MIN_LEN >> 1);
        len_apply = flush_big ? (MIN_LEN >> 1) : (MIN_LEN >> 9);
      end
    endcase
    sum = {1'b0, base} + {1'b0, addend};
  end

  logic [7:0] top_byte;
  logic       wfull, emit_en;
  logic [7:0] emit_byte;

  assign top_byte  = base[31:24];
  assign wfull     = (wcount == 5'(MAX_OUT));
  assign emit_en   = (ctl.op == OP_REL_HEAD) || (ctl.op == OP_REL_TAIL);
  assign emit_byte = (ctl.op == OP_REL_HEAD) ? held : tb;

  always_comb begin
    stat.cmd          = cmd_q;
    stat.raw_zero     = (cnt_q == 6'd0);
    stat.raw_split    = raw_split;
    stat.carry        = carry;
    stat.held_valid   = held_valid;
    stat.pend_zero    = (pend == 5'd0);
    stat.pend_one     = (pend == 5'd1);
    stat.len_small    = (len < MIN_LEN);
    stat.n_done       = (n == 3'd4);
    stat.push_release = held_valid && ((top_byte != BYTE_FF) || (pend == 5'(RUN_BOUND)));
    stat.out_free     = !out_valid || out_ready;
    stat.drain_last   = (ridx == wcount - 5'd1);
    stat.wcount_zero  = (wcount == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      len        <= 32'hFFFF_FFFF;
      held       <= '0;
      held_valid <= 1'b0;
      pend       <= '0;
      ovf        <= 1'b0;
      wcount     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready && (ctl.op != OP_DRAIN)) out_valid <= 1'b0;
      if (emit_en) begin
        if (wfull) begin
          ovf <= 1'b1;
        end else begin
          obuf[wcount[4:0]] <= emit_byte;
          wcount            <= wcount + 5'd1;
        end
      end
      case (ctl.op)
        OP_LOAD: begin
          cmd_q  <= cmd_t'(command);
          bit_q  <= bit_value;
          p_q    <= p_c;
          lo_q   <= lo_c;
          hi_q   <= hi_c;
          last_q <= is_last_symbol;
          cnt_q  <= cnt_c;
          val_q  <= val_c;
          wcount <= '0;
        end
        OP_MUL_LO:    x <= prod[31:0];
        OP_MUL_HI:    y <= prod[31:0];
        OP_RAW_SHIFT: len <= len >> (raw_split ? 5'd16 : cnt_q[4:0]);
        OP_APPLY: begin
          if (do_add) base <= sum[31:0];
          carry <= do_add & sum[32];
          len   <= len_apply;
        end
        OP_CARRY: begin
          if (!held_valid) begin
            ovf <= 1'b1;
          end else begin
            if (held == BYTE_FF) ovf <= 1'b1;
            held <= held + 8'd1;
            if (pend != 5'd0) pend <= pend - 5'd1;
            nb <= BYTE_00;
            tb <= BYTE_00;
          end
        end
        OP_RN_INIT: n <= '0;
        OP_RENORM: begin
          base <= base << 8;
          len  <= len << 8;
          n    <= n + 3'd1;
          nb   <= top_byte;
          tb   <= BYTE_FF;
          if (!held_valid) begin
            held       <= top_byte;
            held_valid <= 1'b1;
          end else if (top_byte == BYTE_FF) begin
            if (pend < 5'(RUN_BOUND)) pend <= pend + 5'd1;
            else ovf <= 1'b1;
          end
        end
        OP_REL_TAIL: pend <= pend - 5'd1;
        OP_REL_DONE: held <= nb;
        OP_RAW_SPLIT: begin
          val_q <= val_q >> 16;
          cnt_q <= cnt_q - 6'd16;
        end
        OP_FINISH: begin
          ridx    <= '0;
          out_ovf <= ovf;
          flushed <= (cmd_q == CMD_FLUSH);
          if (cmd_q == CMD_FLUSH) begin
            base       <= '0;
            len        <= 32'hFFFF_FFFF;
            held       <= '0;
            held_valid <= 1'b0;
            pend       <= '0;
            ovf        <= 1'b0;
          end
        end
        OP_DRAIN: begin
          out_valid    <= 1'b1;
          out_byte     <= obuf[ridx];
          last_of_run  <= stat.drain_last;
          stream_end   <= stat.drain_last & flushed;
          run_overflow <= out_ovf;
          ridx         <= ridx + 5'd1;
        end
        default: ;
      endcase
    end
  end

`include "assert_macros.svh"

  `RCE_ASSERT_ALWAYS(a_pend_bound, clk, rst, pend <= 5'(RUN_BOUND), "pending run past bound")
  `RCE_ASSERT_ALWAYS(a_wcount_bound, clk, rst, wcount <= 5'(MAX_OUT), "result buffer overrun")
  `RCE_ASSERT_NEXT(a_drain_shows, clk, rst, ctl.op == OP_DRAIN, out_valid,
                   "drained byte not presented")

endmodule

/* rtl/core/rce_controller.sv */
module rce_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        command,
  input  rce_pkg::dp_stat_t stat,
  output rce_pkg::dp_ctl_t  ctl,
  output logic              idle
);
  import rce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_RAW_SHIFT, S_APPLY, S_CARRY, S_RN_ENTRY,
    S_RENORM, S_RN_CHK, S_POST, S_REL_HEAD, S_REL_TAIL, S_REL_FIN, S_FINISH, S_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    RET_RN_ENTRY, RET_RN_CHK, RET_FINISH
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;
  op_t    op;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op         = OP_NONE;
    case (state)
      S_IDLE: if (accept) begin
        op = OP_LOAD;
        case (cmd_t'(command))
          CMD_BIT, CMD_SYM: state_next = S_MUL_LO;
          CMD_RAW:          state_next = S_RAW_SHIFT;
          default:          state_next = S_APPLY;
        endcase
      end
      S_RAW_SHIFT: begin
        if (stat.raw_zero) begin
          state_next = S_FINISH;
        end else begin
          op         = OP_RAW_SHIFT;
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        op         = OP_MUL_LO;
        state_next = (stat.cmd == CMD_SYM) ? S_MUL_HI : S_APPLY;
      end
      S_MUL_HI: begin
        op         = OP_MUL_HI;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        op         = OP_APPLY;
        state_next = S_CARRY;
      end
      S_CARRY: begin
        state_next = S_RN_ENTRY;
        if (stat.carry) begin
          op = OP_CARRY;
          if (stat.held_valid && !stat.pend_zero) begin
            ret_next   = RET_RN_ENTRY;
            state_next = S_REL_HEAD;
          end
        end
      end
      S_RN_ENTRY: begin
        op         = OP_RN_INIT;
        state_next = (stat.cmd == CMD_FLUSH || stat.len_small) ? S_RENORM : S_POST;
      end
      S_RENORM: begin
        op         = OP_RENORM;
        state_next = S_RN_CHK;
        if (stat.push_release) begin
          ret_next   = RET_RN_CHK;
          state_next = S_REL_HEAD;
        end
      end
      S_RN_CHK:
        state_next = (stat.len_small && !stat.n_done) ? S_RENORM : S_POST;
      S_POST: begin
        state_next = S_FINISH;
        if (stat.cmd == CMD_RAW && stat.raw_split) begin
          op         = OP_RAW_SPLIT;
          state_next = S_RAW_SHIFT;
        end else if (stat.cmd == CMD_FLUSH && stat.held_valid) begin
          ret_next   = RET_FINISH;
          state_next = S_REL_HEAD;
        end
      end
      S_REL_HEAD: begin
        op         = OP_REL_HEAD;
        state_next = stat.pend_zero ? S_REL_FIN : S_REL_TAIL;
      end
      S_REL_TAIL: begin
        op         = OP_REL_TAIL;
        state_next = stat.pend_one ? S_REL_FIN : S_REL_TAIL;
      end
      S_REL_FIN: begin
        op = OP_REL_DONE;
        case (ret)
          RET_RN_ENTRY: state_next = S_RN_ENTRY;
          RET_RN_CHK:   state_next = S_RN_CHK;
          default:      state_next = S_FINISH;
        endcase
      end
      S_FINISH: begin
        op         = OP_FINISH;
        state_next = stat.wcount_zero ? S_IDLE : S_DRAIN;
      end
      S_DRAIN: if (stat.out_free) begin
        op = OP_DRAIN;
        if (stat.drain_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_RN_ENTRY;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign ctl.op = op;
  assign idle   = (state == S_IDLE);

`include "assert_macros.svh"

  `RCE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE,
                   "accepted command did not start")
  `RCE_ASSERT_ALWAYS(a_accept_only_idle, clk, rst, !accept || state == S_IDLE,
                     "command accepted while busy")

endmodule

/* rtl/core/range_coder_encoder.sv */
// Channel   Modport  Transaction
// request   sink     one command: code bit, code symbol, raw bits or flush
// result    source   one settled byte of the coded stream
//
// From acceptance back to idle a command passes through the single shared
// multiplier (once for a code bit or a raw write of up to 19 bits, twice for a
// code symbol, not for a flush; a split raw write repeats its pass, a raw count
// of zero skips it), then the byte-serial renormalization loop (up to four steps
// per coding step), the release of held bytes and pending runs, and the drain
// of each result.
// Reset (rst, synchronous) restores the empty interval and an empty carry run.
// A stalled result channel holds the drain; a new command is taken once the
// last byte of the previous one sits in the output register.
module range_coder_encoder (
  input logic     clk,
  input logic     rst,
  rce_in_if.sink  request,
  rce_out_if.source result
);
  import rce_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;
  logic     idle;
  logic     accept;

  // The controller sequences every command; the datapath owns the interval,
  // the carry run and the buffer that collects the bytes of one command, so
  // the sticky overflow flag can be stamped on them as it stands at the end.
  assign request.ready = idle;
  assign accept        = request.valid && idle;

  rce_controller u_ctl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (request.command),
    .stat    (stat),
    .ctl     (ctl),
    .idle    (idle)
  );

  rce_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .command        (request.command),
    .bit_value      (request.bit_value),
    .prob_zero      (request.prob_zero),
    .cum_low        (request.cum_low),
    .cum_high       (request.cum_high),
    .is_last_symbol (request.is_last_symbol),
    .raw_count      (request.raw_count),
    .raw_value      (request.raw_value),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_byte       (result.out_byte),
    .last_of_run    (result.last_of_run),
    .stream_end     (result.stream_end),
    .run_overflow   (result.run_overflow)
  );

endmodule
